// ----- sv/assert_macros.svh -----
// assertion macros for the rtl files, included by idq_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(name, clk, rst, expr) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(name, clk, rst, prop)
`define ASSERT_NEVER(name, clk, rst, expr)

`endif

`endif

// ----- sv/idq_pkg.sv -----
// shared types and constants of the integer deque with search
package idq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VALUE_W   = 32;
  localparam int COUNT_W   = 5;
  localparam int OPCODE_W  = 3;

  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_SEARCH     = 3'd4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FETCH,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// ----- sv/integer_deque_with_search.sv -----
// top level of the integer deque with search
//
// bounded double-ended queue of signed 32-bit numbers kept in a ring store
// command channel: cmd_valid / cmd_stall with opcode and value; one
// transaction per command (push front, push back, pop front, pop back,
// search); unused opcodes leave the queue untouched and report ok
// result channel: res_valid / res_stall with status, count, front_value
// and front_valid; exactly one result transaction per command
// a push or a pop passes execute, front read and result load before its
// result reaches the result register; a search executes, scans the stored
// entries until a hit or the last, then does front read and result load;
// the single compare unit checks one store entry per cycle behind
// the read port of the ring store
// a new command is taken in the cycle after the result loads, while the
// previous result may still wait in the output register
// a stalled result holds; the next command's result waits in the
// sequencer until the output register is free
// reset empties the queue at once (head and count cleared); store
// contents are not cleared and no clearing pass is needed
module integer_deque_with_search
  import idq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  logic        [OPCODE_W-1:0] opcode,
  input  logic signed [VALUE_W-1:0]  value,
  output logic                       res_valid,
  input  logic                       res_stall,
  output logic        [1:0]          status,
  output logic        [COUNT_W-1:0]  count,
  output logic signed [VALUE_W-1:0]  front_value,
  output logic                       front_valid
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  mem_ctl_t           mem_ctl;
  logic [AW-1:0]      wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic [AW-1:0]      rd_addr;
  logic [VALUE_W-1:0] rd_data;

  idq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .opcode      (opcode),
    .value       (value),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .status      (status),
    .count       (count),
    .front_value (front_value),
    .front_valid (front_valid),
    .mem_ctl     (mem_ctl),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  idq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ----- sv/idq_store.sv -----
// ring store: one write port and one registered read port
module idq_store
  import idq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  mem_ctl_t           ctl,
  input  logic [AW-1:0]      wr_addr,
  input  logic [VALUE_W-1:0] wr_data,
  input  logic [AW-1:0]      rd_addr,
  output logic [VALUE_W-1:0] rd_data
);

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/idq_ctrl.sv -----
// sequencer, pointers, search compare and result register of the deque
`include "assert_macros.svh"

module idq_ctrl
  import idq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  logic        [OPCODE_W-1:0] opcode,
  input  logic signed [VALUE_W-1:0]  value,
  output logic                       res_valid,
  input  logic                       res_stall,
  output logic        [1:0]          status,
  output logic        [COUNT_W-1:0]  count,
  output logic signed [VALUE_W-1:0]  front_value,
  output logic                       front_valid,
  output mem_ctl_t                   mem_ctl,
  output logic        [AW-1:0]       wr_addr,
  output logic        [VALUE_W-1:0]  wr_data,
  output logic        [AW-1:0]       rd_addr,
  input  logic        [VALUE_W-1:0]  rd_data
);

  localparam logic [CW-1:0] FULL_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_C = AW'(DEPTH - 1);
  localparam logic [AW:0]   WRAP_C = (AW + 1)'(DEPTH);

  state_t               state, state_next;
  logic [OPCODE_W-1:0]  op;
  logic [VALUE_W-1:0]   val;
  logic [AW-1:0]        head, head_next;
  logic [CW-1:0]        cnt, cnt_next;
  logic [AW-1:0]        ptr, ptr_next;
  logic [CW-1:0]        left, left_next;
  status_t              stat, stat_next;
  logic                 res_load;
  logic                 hit;
  logic [AW:0]          tail_sum;
  logic [AW-1:0]        tail;
  logic [AW-1:0]        head_dec;
  logic [AW-1:0]        head_inc;
  logic [AW-1:0]        ptr_inc;

  // the shared compare unit, one stored entry per cycle
  assign hit = (rd_data == val);

  assign tail_sum = (AW + 1)'(head) + (AW + 1)'(cnt);
  assign tail     = (tail_sum >= WRAP_C) ? AW'(tail_sum - WRAP_C) : AW'(tail_sum);
  assign head_dec = (head == '0) ? LAST_C : head - 1'b1;
  assign head_inc = (head == LAST_C) ? '0 : head + 1'b1;
  assign ptr_inc  = (ptr == LAST_C) ? '0 : ptr + 1'b1;

  assign cmd_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (op == OP_SEARCH && cnt != '0) state_next = S_SCAN;
        else state_next = S_FETCH;
      end
      S_SCAN: begin
        if (hit || left == '0) state_next = S_FETCH;
      end
      S_FETCH: state_next = S_LOAD;
      S_LOAD: begin
        if (!res_valid || !res_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    head_next     = head;
    cnt_next      = cnt;
    ptr_next      = ptr;
    left_next     = left;
    stat_next     = stat;
    mem_ctl.rd_en = 1'b0;
    mem_ctl.wr_en = 1'b0;
    wr_addr       = tail;
    wr_data       = val;
    rd_addr       = head;
    res_load      = 1'b0;
    case (state)
      S_EXEC: begin
        stat_next = ST_OK;
        case (op)
          OP_PUSH_FRONT: begin
            if (cnt == FULL_C) begin
              stat_next = ST_FULL;
            end else begin
              head_next     = head_dec;
              wr_addr       = head_dec;
              mem_ctl.wr_en = 1'b1;
              cnt_next      = cnt + 1'b1;
            end
          end
          OP_PUSH_BACK: begin
            if (cnt == FULL_C) begin
              stat_next = ST_FULL;
            end else begin
              wr_addr       = tail;
              mem_ctl.wr_en = 1'b1;
              cnt_next      = cnt + 1'b1;
            end
          end
          OP_POP_FRONT: begin
            if (cnt == '0) begin
              stat_next = ST_EMPTY;
            end else begin
              head_next = head_inc;
              cnt_next  = cnt - 1'b1;
            end
          end
          OP_POP_BACK: begin
            if (cnt == '0) begin
              stat_next = ST_EMPTY;
            end else begin
              cnt_next = cnt - 1'b1;
            end
          end
          OP_SEARCH: begin
            stat_next = ST_MISS;
            // first read goes out now, compare starts next cycle
            if (cnt != '0) begin
              mem_ctl.rd_en = 1'b1;
              rd_addr       = head;
              ptr_next      = head_inc;
              left_next     = cnt - 1'b1;
            end
          end
          default: stat_next = ST_OK;
        endcase
      end
      S_SCAN: begin
        if (hit) begin
          stat_next = ST_OK;
        end else if (left != '0) begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = ptr;
          ptr_next      = ptr_inc;
          left_next     = left - 1'b1;
        end
      end
      S_FETCH: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = head;
      end
      S_LOAD: begin
        res_load = !res_valid || !res_stall;
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      cnt   <= cnt_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) begin
      op  <= opcode;
      val <= value;
    end
    ptr  <= ptr_next;
    left <= left_next;
    stat <= stat_next;
    if (res_load) begin
      status      <= stat;
      count       <= COUNT_W'(cnt);
      front_valid <= (cnt != '0);
      front_value <= (cnt != '0) ? rd_data : '0;
    end
  end

  `ASSERT_PROP(a_cnt_bound, clk, rst, cnt <= FULL_C)
  `ASSERT_PROP(a_scan_in_range, clk, rst, state == S_SCAN |-> left < cnt)
  `ASSERT_PROP(a_accept_exec, clk, rst, cmd_valid && !cmd_stall |=> state == S_EXEC)
  `ASSERT_PROP(a_full_push_keeps, clk, rst,
    state == S_EXEC && cnt == FULL_C && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)
    |=> cnt == $past(cnt) && head == $past(head))
  `ASSERT_NEVER(a_write_outside_exec, clk, rst, mem_ctl.wr_en && state != S_EXEC)

endmodule
